@@ hdl/imf3_pkg.sv @@
// Shared constants and types for the 3x3 zero-border image filter.
// No dependencies; used by image_filter_3x3_zero_border.
package imf3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 24;
	localparam int SHIFT_W = 3;
	localparam int DIM_W   = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int EMIT_W  = 20;
	localparam int AREA_W  = EMIT_W + 1;
	localparam int PROD_W  = 17;
	localparam int SUM_W   = 20;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOP_ROW    = 3'd0,
		CFG_MIDDLE_ROW = 3'd1,
		CFG_BOTTOM_ROW = 3'd2,
		CFG_SHIFT      = 3'd3,
		CFG_WIDTH      = 3'd4,
		CFG_HEIGHT     = 3'd5
	} cfg_reg_t;

	localparam logic [COEF_W-1:0] TOP_RESET    = 24'h000000;
	localparam logic [COEF_W-1:0] MIDDLE_RESET = 24'h000100;
	localparam logic [COEF_W-1:0] BOTTOM_RESET = 24'h000000;
	localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

	// 3x3 neighborhood: [row][column][bit], row 0 is the top, column 0 the left
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	// Neighbors that fall outside the image
	typedef struct packed {
		logic up;
		logic down;
		logic lt;
		logic rt;
	} border_t;

	// Clamp a programmed dimension to 1..maxv
	function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > maxv)
			r = maxv;
		return r;
	endfunction

endpackage

@@ hdl/image_filter_3x3_zero_border.sv @@
// 3x3 correlation filter with zero border over a raster stream of grey pixels.
// Depends on imf3_pkg (constants, window and border types).
//
//  channel   dir  beat holds
//  s_axis    in   tuser: kind (1 = flush), tdata: pixel_in
//  m_axis    out  tdata: pixel_out, tlast: frame_end
//  cfg       in   cfg_we / cfg_index / cfg_wdata, one register per write
//
// One item per clock while the output is not stalled: three register stages, which are
// stage 1 (counters and line-store read at the accepting edge), stage 2 (window and
// products) and the output register (sum and clamp). The line store is one 1024 x 16
// memory with a single read and write port; a same-address read at the edge of a
// write is served by a bypass.
// Reset clears counters, window and valid flags; the line store is not cleared.
// A stalled output holds every stage; nothing is dropped.
module image_filter_3x3_zero_border (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [imf3_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel_in
	input  logic                           s_axis_tuser,  // [0] kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [imf3_pkg::PIX_W-1:0]     m_axis_tdata,  // [7:0] pixel_out
	output logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic [imf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imf3_pkg::COEF_W-1:0]    cfg_wdata
);

	localparam int PIX_W  = imf3_pkg::PIX_W;
	localparam int COL_W  = imf3_pkg::COL_W;
	localparam int DIM_W  = imf3_pkg::DIM_W;
	localparam int EMIT_W = imf3_pkg::EMIT_W;
	localparam int AREA_W = imf3_pkg::AREA_W;
	localparam int PROD_W = imf3_pkg::PROD_W;
	localparam int SUM_W  = imf3_pkg::SUM_W;
	localparam int LINE_W = 2 * PIX_W;

	// Configuration
	logic [2:0][imf3_pkg::COEF_W-1:0] coef_q;
	logic [imf3_pkg::SHIFT_W-1:0]     shift_q;
	logic [DIM_W-1:0]                 width_q;
	logic [DIM_W-1:0]                 height_q;
	logic [AREA_W-1:0]                area_q;
	logic [2*DIM_W-1:0]               area_full;

	// Position counters
	logic [COL_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [EMIT_W-1:0] emitted_q;

	logic en;
	logic acc;

	// Item entering
	logic                  use_prev_s0;
	logic                  emit_s0;
	logic                  last_s0;
	logic [DIM_W-1:0]      qr_s0;
	imf3_pkg::border_t     border_s0;
	logic                  wrap_s0;

	// Stage 1
	logic                  valid_s1;
	logic [PIX_W-1:0]      pix_s1;
	logic [COL_W-1:0]      addr_s1;
	logic                  use_prev_s1;
	logic                  emit_s1;
	logic                  last_s1;
	imf3_pkg::border_t     border_s1;
	logic                  fwd_s1;
	logic [LINE_W-1:0]     fwd_data_s1;
	logic [LINE_W-1:0]     rd_s1;
	logic [LINE_W-1:0]     line_eff;
	imf3_pkg::win_t        window_q;
	imf3_pkg::win_t        win_new;
	imf3_pkg::win_t        win_sel;
	logic signed [PROD_W-1:0] prod [9];

	logic [LINE_W-1:0] line_mem [imf3_pkg::MAX_WIDTH];

	// Stage 2
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2 [9];
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  shifted;
	logic [PIX_W-1:0]         clamped;

	// Output register
	logic             out_valid_q;
	logic             out_last_q;
	logic [PIX_W-1:0] out_pixel_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && en;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= imf3_pkg::TOP_RESET;
			coef_q[1] <= imf3_pkg::MIDDLE_RESET;
			coef_q[2] <= imf3_pkg::BOTTOM_RESET;
			shift_q   <= '0;
			width_q   <= imf3_pkg::WIDTH_RESET;
			height_q  <= imf3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (imf3_pkg::cfg_reg_t'(cfg_index))
				imf3_pkg::CFG_TOP_ROW:    coef_q[0] <= cfg_wdata;
				imf3_pkg::CFG_MIDDLE_ROW: coef_q[1] <= cfg_wdata;
				imf3_pkg::CFG_BOTTOM_ROW: coef_q[2] <= cfg_wdata;
				imf3_pkg::CFG_SHIFT:      shift_q   <= cfg_wdata[imf3_pkg::SHIFT_W-1:0];
				imf3_pkg::CFG_WIDTH:      width_q   <= imf3_pkg::dim_clamp(
						cfg_wdata[DIM_W-1:0], imf3_pkg::WIDTH_RESET);
				imf3_pkg::CFG_HEIGHT:     height_q  <= imf3_pkg::dim_clamp(
						cfg_wdata[DIM_W-1:0], imf3_pkg::HEIGHT_RESET);
				default: ;
			endcase
		end
	end

	assign area_full = width_q * height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			area_q <= AREA_W'(imf3_pkg::MAX_WIDTH * imf3_pkg::MAX_HEIGHT);
		else
			area_q <= area_full[AREA_W-1:0];
	end

	// ---------------- entry: position and border decisions ----------------
	always_comb begin
		use_prev_s0 = (col_q == '0);
		emit_s0     = use_prev_s0 ? (row_q >= DIM_W'(2)) : (row_q != '0);
		last_s0     = emit_s0 && ((AREA_W'(emitted_q) + AREA_W'(1)) >= area_q);
		// centre row of the result: the row before last when the row just wrapped
		qr_s0       = use_prev_s0 ? (row_q - DIM_W'(2)) : (row_q - DIM_W'(1));
		border_s0.up   = (qr_s0 == '0);
		border_s0.down = ({1'b0, qr_s0} + (DIM_W+1)'(1)) >= {1'b0, height_q};
		border_s0.lt   = use_prev_s0 ? (width_q == DIM_W'(1)) : (col_q == COL_W'(1));
		border_s0.rt   = use_prev_s0 ? 1'b1 : (DIM_W'(col_q) >= width_q);
		wrap_s0        = (DIM_W'(col_q) + DIM_W'(1)) >= width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (acc) begin
			if (last_s0) begin
				col_q     <= '0;
				row_q     <= '0;
				emitted_q <= '0;
			end else begin
				if (emit_s0)
					emitted_q <= emitted_q + EMIT_W'(1);
				if (wrap_s0) begin
					col_q <= '0;
					if (row_q != '1)
						row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			// previous item writes this address at the same edge: bypass
			fwd_s1   <= valid_s1 && (addr_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1      <= s_axis_tuser ? '0 : s_axis_tdata;
			addr_s1     <= col_q;
			use_prev_s1 <= use_prev_s0;
			emit_s1     <= emit_s0;
			last_s1     <= last_s0;
			border_s1   <= border_s0;
			fwd_data_s1 <= {line_eff[PIX_W-1:0], pix_s1};
		end
	end

	// Line store: [15:8] older row, [7:0] newer row
	always_ff @(posedge clk) begin
		if (en)
			rd_s1 <= line_mem[col_q];
		if (en && valid_s1)
			line_mem[addr_s1] <= {line_eff[PIX_W-1:0], pix_s1};
	end

	assign line_eff = fwd_s1 ? fwd_data_s1 : rd_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_new[i][0] = window_q[i][1];
			win_new[i][1] = window_q[i][2];
		end
		win_new[0][2] = line_eff[LINE_W-1:PIX_W];
		win_new[1][2] = line_eff[PIX_W-1:0];
		win_new[2][2] = pix_s1;
		// first column of a row: the result is the last pixel of the earlier row
		win_sel = use_prev_s1 ? window_q : win_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= '0;
		else if (en && valid_s1)
			window_q <= last_s1 ? '0 : win_new;
	end

	always_comb begin
		logic             off;
		logic [PIX_W-1:0] p;
		logic [7:0]       w;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				off = (i == 0 && border_s1.up) || (i == 2 && border_s1.down) ||
				      (j == 0 && border_s1.lt) || (j == 2 && border_s1.rt);
				p   = off ? '0 : win_sel[i][j];
				w   = coef_q[i][8*j +: 8];
				prod[3*i+j] = $signed(w) * $signed({1'b0, p});
			end
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s2 <= last_s1;
			for (int k = 0; k < 9; k++)
				prod_s2[k] <= prod[k];
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < 9; k++)
			sum = sum + {{(SUM_W-PROD_W){prod_s2[k][PROD_W-1]}}, prod_s2[k]};
		shifted = sum >>> shift_q;
		if (shifted < 0)
			clamped = '0;
		else if (shifted > SUM_W'(255))
			clamped = '1;
		else
			clamped = shifted[PIX_W-1:0];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pixel_q <= clamped;
			out_last_q  <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pixel_q;
	assign m_axis_tlast  = out_last_q;

	// ---------------- assertions ----------------
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_s0 |=> col_q == '0 && row_q == '0 && emitted_q == '0)
		else $error("counters not cleared after the frame's last beat");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit_s0 && !last_s0 |=> emitted_q == $past(emitted_q) + EMIT_W'(1))
		else $error("emitted count did not advance on a result");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && last_s1 |=> window_q == '0)
		else $error("window not cleared at frame end");

endmodule
